/* rtl/core/csr_sparse_matrix_vector_multiply_assert.svh */
// assertion macros for the sparse matrix-vector block
// expects i_clk and i_rst_n in the module that uses them
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// same-cycle implication
`define CSMV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSMV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/csmv_pkg.sv */
// shared types and constants for the sparse matrix-vector block
// no dependencies
package csmv_pkg;

    localparam int DATA_W           = 32;
    localparam int SUM_W            = 64;
    localparam int ROW_W            = 16;
    localparam int POS_W            = 10;
    localparam int FUNC_W           = 2;
    localparam int POS_EXT_W        = 17;
    localparam int VECTOR_DEPTH_DEF = 1024;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EMPTY   = 2'd2;

    // request after the vector store read has been issued
    typedef struct packed {
        logic                     valid;
        logic                     empty_row;
        logic                     row_end;
        logic                     in_range;
        logic signed [DATA_W-1:0] data;
    } t_s1;

    // request after the multiply
    typedef struct packed {
        logic                    valid;
        logic                    empty_row;
        logic                    row_end;
        logic signed [SUM_W-1:0] prod;
    } t_s2;

endpackage

/* rtl/core/csmv_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module csmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/csmv_mac.sv */
// multiply, saturating row accumulate and output register
// depends on csmv_pkg and the assertion macro header
`include "csr_sparse_matrix_vector_multiply_assert.svh"

module csmv_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  csmv_pkg::t_s1                    i_s1,
    input  logic [csmv_pkg::DATA_W-1:0]      i_entry,
    input  logic                             i_out_stall,
    output logic                             o_adv,
    output logic                             o_out_valid,
    output logic signed [csmv_pkg::SUM_W-1:0] o_row_sum,
    output logic [csmv_pkg::ROW_W-1:0]       o_row_number
);

    localparam int SW = csmv_pkg::SUM_W;

    csmv_pkg::t_s2 r_s2, n_s2;
    logic signed [SW-1:0] r_acc, n_acc;
    logic [csmv_pkg::ROW_W-1:0] r_count, n_count;
    logic r_out_valid, n_out_valid;
    logic signed [SW-1:0] r_row_sum, n_row_sum;
    logic [csmv_pkg::ROW_W-1:0] r_row_number, n_row_number;

    logic signed [csmv_pkg::DATA_W-1:0] entry_s;
    logic signed [SW-1:0] sum_raw, sum_sat;
    logic adv, ovf, emit;

    assign adv = !(r_out_valid && i_out_stall);

    // out-of-range columns read as zero
    assign entry_s = i_s1.in_range ? $signed(i_entry) : '0;

    always_comb begin
        n_s2 = r_s2;
        if (adv) begin
            n_s2.valid     = i_s1.valid;
            n_s2.empty_row = i_s1.empty_row;
            n_s2.row_end   = i_s1.row_end;
            n_s2.prod      = i_s1.data * entry_s;
        end
    end

    // overflow when both addends share a sign the sum does not
    assign sum_raw = r_acc + r_s2.prod;
    assign ovf     = (r_acc[SW-1] == r_s2.prod[SW-1]) && (sum_raw[SW-1] != r_acc[SW-1]);
    always_comb begin
        sum_sat = sum_raw;
        if (ovf) begin
            sum_sat = r_s2.prod[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
    end

    assign emit = adv && r_s2.valid && (r_s2.empty_row || r_s2.row_end);

    always_comb begin
        n_acc        = r_acc;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_row_sum    = r_row_sum;
        n_row_number = r_row_number;
        if (adv) begin
            n_out_valid = emit;
            if (r_s2.valid) begin
                if (r_s2.empty_row) begin
                    n_row_sum = '0;
                end else if (r_s2.row_end) begin
                    n_row_sum = sum_sat;
                    n_acc     = '0;
                end else begin
                    n_acc = sum_sat;
                end
                if (emit) begin
                    n_row_number = r_count;
                    n_count      = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid  <= 1'b0;
            r_acc       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s2.valid  <= n_s2.valid;
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_s2.empty_row <= n_s2.empty_row;
        r_s2.row_end   <= n_s2.row_end;
        r_s2.prod      <= n_s2.prod;
        r_row_sum      <= n_row_sum;
        r_row_number   <= n_row_number;
    end

    assign o_adv        = adv;
    assign o_out_valid  = r_out_valid;
    assign o_row_sum    = r_row_sum;
    assign o_row_number = r_row_number;

    `CSMV_ASSERT_NEXT(a_stall_holds_acc, r_out_valid && i_out_stall, r_acc == $past(r_acc), "accumulator moved during output stall")
    `CSMV_ASSERT_NEXT(a_emit_counts, emit, r_count == $past(r_count) + 1'b1 && r_out_valid, "row counter did not follow an emitted row")
    `CSMV_ASSERT_NEXT(a_row_end_clears, adv && r_s2.valid && !r_s2.empty_row && r_s2.row_end, r_acc == '0, "accumulator not cleared after row end")

endmodule

/* rtl/core/csr_sparse_matrix_vector_multiply.sv */
// Sparse matrix times dense vector in compressed-row order.
// Input channel (i_in_valid / o_in_stall) carries one request per cycle while o_in_stall is low:
//   func load writes i_data_value into the vector store at i_vector_position,
//   func nonzero multiplies i_data_value by the stored entry of that column and
//   adds the Q32.32 product into the saturating row accumulator; with i_row_end
//   set the row sum and row number are sent out and the accumulator clears,
//   func empty row sends a zero sum for the next row number.
// Output channel (o_out_valid / i_out_stall) carries o_row_sum, o_row_number.
// Throughput: one request per cycle while o_in_stall is low, loads and nonzeros freely interleaved.
// Between acceptance and the output a request passes the store read (into r_s1), the
//   multiply (into r_s2) and the accumulate into the output register.
// A nonzero may read an entry loaded by the request just before it.
// Reset (synchronous, active low) clears the accumulator, the row counter and
//   all valid flags; vector store contents are kept and must be loaded first.
// While a result waits under i_out_stall the whole pipeline holds and
//   o_in_stall is raised in the same cycle.
module csr_sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = csmv_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [csmv_pkg::FUNC_W-1:0]       i_func,
    input  logic [csmv_pkg::POS_W-1:0]        i_vector_position,
    input  logic signed [csmv_pkg::DATA_W-1:0] i_data_value,
    input  logic                              i_row_end,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [csmv_pkg::SUM_W-1:0] o_row_sum,
    output logic [csmv_pkg::ROW_W-1:0]        o_row_number
);

    localparam int AW = $clog2(VECTOR_DEPTH);

    csmv_pkg::t_s1 r_s1, n_s1;
    logic adv, accept, in_range, is_load, is_nonzero, is_empty;
    logic [csmv_pkg::POS_EXT_W-1:0] pos_ext;
    logic [AW-1:0] addr;
    logic [csmv_pkg::DATA_W-1:0] entry;

    assign accept     = i_in_valid && adv;
    assign o_in_stall = !adv;

    assign pos_ext  = csmv_pkg::POS_EXT_W'(i_vector_position);
    assign addr     = pos_ext[AW-1:0];
    assign in_range = pos_ext < csmv_pkg::POS_EXT_W'(VECTOR_DEPTH);

    assign is_load    = i_func == csmv_pkg::FUNC_LOAD;
    assign is_nonzero = i_func == csmv_pkg::FUNC_NONZERO;
    assign is_empty   = i_func == csmv_pkg::FUNC_EMPTY;

    csmv_ram #(
        .WIDTH(csmv_pkg::DATA_W),
        .DEPTH(VECTOR_DEPTH)
    ) u_vec (
        .i_clk  (i_clk),
        .i_we   (accept && is_load && in_range),
        .i_waddr(addr),
        .i_wdata(i_data_value),
        .i_re   (accept && is_nonzero),
        .i_raddr(addr),
        .o_rdata(entry)
    );

    always_comb begin
        n_s1 = r_s1;
        if (adv) begin
            n_s1.valid     = accept && (is_nonzero || is_empty);
            n_s1.empty_row = is_empty;
            n_s1.row_end   = i_row_end;
            n_s1.in_range  = in_range;
            n_s1.data      = i_data_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.empty_row <= n_s1.empty_row;
        r_s1.row_end   <= n_s1.row_end;
        r_s1.in_range  <= n_s1.in_range;
        r_s1.data      <= n_s1.data;
    end

    csmv_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (r_s1),
        .i_entry     (entry),
        .i_out_stall (i_out_stall),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_row_sum   (o_row_sum),
        .o_row_number(o_row_number)
    );

endmodule
